[rtl/rfd_pkg.sv]
package rfd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MAGIC     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ID_LENGTH      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE_LENGTH = 2'd3;

    localparam logic [31:0] RST_EXPECTED_MAGIC     = 32'd0;
    localparam logic [7:0]  RST_EXPECTED_VERSION   = 8'd1;
    localparam logic [7:0]  RST_MAX_ID_LENGTH      = 8'd64;
    localparam logic [31:0] RST_MAX_MESSAGE_LENGTH = 32'd65536;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_ID      = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_DROP    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MAGIC   = 3'd1;
    localparam logic [2:0] ST_IDLEN   = 3'd2;
    localparam logic [2:0] ST_TOOLONG = 3'd3;
    localparam logic [2:0] ST_VERSION = 3'd4;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_IDLEN   = 3'd2,
        PH_IDVAL   = 3'd3,
        PH_MSGLEN  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CLOSED  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [7:0]  expected_version;
        logic [7:0]  max_id_length;
        logic [31:0] max_message_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0] byte_kind;
        logic [7:0] byte_value;
        logic       field_last;
        logic       frame_end;
        logic [2:0] status;
    } result_t;

endpackage

[rtl/rfd_rx_if.sv]
interface rfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/rfd_tx_if.sv]
interface rfd_tx_if;
    logic       valid;
    logic       ready;
    logic [1:0] byte_kind;
    logic [7:0] byte_value;
    logic       field_last;
    logic       frame_end;
    logic [2:0] status;

    modport source (output valid, output byte_kind, output byte_value, output field_last,
                    output frame_end, output status, input ready);
    modport sink (input valid, input byte_kind, input byte_value, input field_last,
                  input frame_end, input status, output ready);
endinterface

[rtl/rpc_frame_deframer_top.sv]
// Frame deframer: parses a byte stream of magic / version / id-length / id /
// message-length / payload frames and returns one result transaction per byte,
// in order. Throughput is one byte per cycle while tx.ready is high; an
// accepted rx byte passes the input register, one parse step and the result
// register on its way to tx. A bad magic, bad id length or oversized message
// length closes the link: later bytes come back as discards until reset.
// Write the configuration registers only while no transaction is in flight.
module rpc_frame_deframer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    rfd_rx_if.sink                              rx,
    rfd_tx_if.source                            tx
);

    rfd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    rfd_pkg::result_t out_result_reg;
    rfd_pkg::result_t parse_result;
    logic             advance;
    logic             rx_take;

    assign advance  = in_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    assign in_valid_next  = rx_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (tx.ready ? 1'b0 : out_valid_reg);

    rfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic     <= rfd_pkg::RST_EXPECTED_MAGIC;
            cfg_reg.expected_version   <= rfd_pkg::RST_EXPECTED_VERSION;
            cfg_reg.max_id_length      <= rfd_pkg::RST_MAX_ID_LENGTH;
            cfg_reg.max_message_length <= rfd_pkg::RST_MAX_MESSAGE_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfd_pkg::CFG_EXPECTED_MAGIC:     cfg_reg.expected_magic     <= cfg_wdata;
                rfd_pkg::CFG_EXPECTED_VERSION:   cfg_reg.expected_version   <= cfg_wdata[7:0];
                rfd_pkg::CFG_MAX_ID_LENGTH:      cfg_reg.max_id_length      <= cfg_wdata[7:0];
                rfd_pkg::CFG_MAX_MESSAGE_LENGTH: cfg_reg.max_message_length <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            out_result_reg <= parse_result;
        end
    end

    assign tx.valid      = out_valid_reg;
    assign tx.byte_kind  = out_result_reg.byte_kind;
    assign tx.byte_value = out_result_reg.byte_value;
    assign tx.field_last = out_result_reg.field_last;
    assign tx.frame_end  = out_result_reg.frame_end;
    assign tx.status     = out_result_reg.status;

endmodule

[rtl/rfd_parser.sv]
module rfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  rfd_pkg::cfg_t       cfg,
    output rfd_pkg::result_t    result
);

    rfd_pkg::phase_t phase_reg;
    rfd_pkg::phase_t phase_next;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;
    logic [31:0]     acc_reg;
    logic [31:0]     acc_next;
    logic [31:0]     rem_reg;
    logic [31:0]     rem_next;

    logic [31:0] word;
    logic        word_done;
    logic        rem_last;
    logic        magic_bad;
    logic        idlen_bad;
    logic        len_too_long;
    logic        len_zero;

    assign word         = {acc_reg[23:0], rx_byte};
    assign word_done    = (idx_reg == 2'd3);
    assign rem_last     = (rem_reg[31:1] == 31'd0);
    assign magic_bad    = (word != cfg.expected_magic);
    assign idlen_bad    = (rx_byte == 8'd0) || (rx_byte > cfg.max_id_length);
    assign len_too_long = (word > cfg.max_message_length);
    assign len_zero     = (word == 32'd0);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        case (phase_reg)
            rfd_pkg::PH_MAGIC,
            rfd_pkg::PH_MSGLEN:
            begin
                idx_next = idx_reg + 2'd1;
                if (word_done)
                begin
                    acc_next = 32'd0;
                    if (phase_reg == rfd_pkg::PH_MAGIC)
                    begin
                        phase_next = magic_bad ? rfd_pkg::PH_CLOSED : rfd_pkg::PH_VERSION;
                    end
                    else if (len_too_long)
                    begin
                        phase_next = rfd_pkg::PH_CLOSED;
                    end
                    else if (len_zero)
                    begin
                        phase_next = rfd_pkg::PH_MAGIC;
                    end
                    else
                    begin
                        rem_next   = word;
                        phase_next = rfd_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    acc_next = word;
                end
            end
            rfd_pkg::PH_VERSION:
            begin
                phase_next = rfd_pkg::PH_IDLEN;
            end
            rfd_pkg::PH_IDLEN:
            begin
                if (idlen_bad)
                begin
                    phase_next = rfd_pkg::PH_CLOSED;
                end
                else
                begin
                    rem_next   = {24'd0, rx_byte};
                    phase_next = rfd_pkg::PH_IDVAL;
                end
            end
            rfd_pkg::PH_IDVAL,
            rfd_pkg::PH_PAYLOAD:
            begin
                if (rem_last)
                begin
                    rem_next   = 32'd0;
                    idx_next   = 2'd0;
                    acc_next   = 32'd0;
                    phase_next = (phase_reg == rfd_pkg::PH_IDVAL) ? rfd_pkg::PH_MSGLEN
                                                                  : rfd_pkg::PH_MAGIC;
                end
                else
                begin
                    rem_next = rem_reg - 32'd1;
                end
            end
            default:
            begin
                phase_next = rfd_pkg::PH_CLOSED;
            end
        endcase
    end

    // result
    always_comb
    begin
        result.byte_kind  = rfd_pkg::KIND_HEADER;
        result.byte_value = rx_byte;
        result.field_last = 1'b0;
        result.frame_end  = 1'b0;
        result.status     = rfd_pkg::ST_OK;
        case (phase_reg)
            rfd_pkg::PH_MAGIC:
            begin
                if (word_done && magic_bad)
                begin
                    result.status = rfd_pkg::ST_MAGIC;
                end
            end
            rfd_pkg::PH_VERSION:
            begin
                if (rx_byte != cfg.expected_version)
                begin
                    result.status = rfd_pkg::ST_VERSION;
                end
            end
            rfd_pkg::PH_IDLEN:
            begin
                if (idlen_bad)
                begin
                    result.status = rfd_pkg::ST_IDLEN;
                end
            end
            rfd_pkg::PH_IDVAL:
            begin
                result.byte_kind  = rfd_pkg::KIND_ID;
                result.field_last = rem_last;
            end
            rfd_pkg::PH_MSGLEN:
            begin
                if (word_done)
                begin
                    if (len_too_long)
                    begin
                        result.status = rfd_pkg::ST_TOOLONG;
                    end
                    else
                    begin
                        result.frame_end = len_zero;
                    end
                end
            end
            rfd_pkg::PH_PAYLOAD:
            begin
                result.byte_kind  = rfd_pkg::KIND_PAYLOAD;
                result.field_last = rem_last;
                result.frame_end  = rem_last;
            end
            default:
            begin
                result.byte_kind = rfd_pkg::KIND_DROP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rfd_pkg::PH_MAGIC;
            idx_reg   <= 2'd0;
            acc_reg   <= 32'd0;
            rem_reg   <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
        end
    end

endmodule
